>>> rtl/srsc_pkg.sv
// ----------------------------------------------------------------------------
// srsc_pkg: shared types and constants of the rectangle scissor clipper.
// Holds the configuration register indexes.
// ----------------------------------------------------------------------------
`default_nettype none
package srsc_pkg;

  typedef enum logic [1:0] {
    REG_WINDOW_LEFT   = 2'd0,
    REG_WINDOW_TOP    = 2'd1,
    REG_WINDOW_WIDTH  = 2'd2,
    REG_WINDOW_HEIGHT = 2'd3
  } reg_idx_e;

  localparam int unsigned CfgIdxBits = 2;
  localparam int unsigned CfgDataBits = 13;
  localparam int unsigned WinPosBits = 12;
  localparam int unsigned WinSizeBits = 13;

endpackage
`default_nettype wire

>>> rtl/srsc_div.sv
// ----------------------------------------------------------------------------
// srsc_div: pipelined signed divider, truncating toward zero.
// One quotient bit per stage over magnitudes; one beat may enter each cycle that en_i is high.
// ----------------------------------------------------------------------------
`default_nettype none
module srsc_div #(
  parameter int unsigned NUM_BITS = 32,
  parameter int unsigned DEN_BITS = 13
) (
  input  wire logic                       clk_i,
  input  wire logic                       en_i,
  input  wire logic signed [NUM_BITS-1:0] num_i,
  input  wire logic        [DEN_BITS-1:0] den_i,
  output logic signed [NUM_BITS-1:0]      quo_o
);

  localparam int unsigned Stages = NUM_BITS;

  logic [NUM_BITS-1:0] rem_q [Stages+1];
  logic [NUM_BITS-1:0] quo_q [Stages+1];
  logic [DEN_BITS-1:0] den_q [Stages+1];
  logic                neg_q [Stages+1];

  // Stage zero takes the magnitude of the numerator.
  always_comb begin
    neg_q[0] = num_i[NUM_BITS-1];
    rem_q[0] = num_i[NUM_BITS-1] ? NUM_BITS'(-num_i) : NUM_BITS'(num_i);
    quo_q[0] = '0;
    den_q[0] = den_i;
  end

  // Restoring division, one bit from the top per stage.
  for (genvar s = 0; s < Stages; s++) begin : g_stage
    localparam int unsigned B = Stages - 1 - s;
    logic [NUM_BITS+DEN_BITS-1:0] sh_den;
    logic [NUM_BITS+DEN_BITS-1:0] rem_ext;
    logic                         fits;
    assign sh_den  = (NUM_BITS+DEN_BITS)'(den_q[s]) << B;
    assign rem_ext = (NUM_BITS+DEN_BITS)'(rem_q[s]);
    assign fits    = rem_ext >= sh_den;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1] <= fits ? NUM_BITS'(rem_ext - sh_den) : rem_q[s];
        quo_q[s+1] <= quo_q[s] | (NUM_BITS'(fits) << B);
        den_q[s+1] <= den_q[s];
        neg_q[s+1] <= neg_q[s];
      end
    end
  end

  assign quo_o = neg_q[Stages] ? NUM_BITS'(-quo_q[Stages]) : NUM_BITS'(quo_q[Stages]);

endmodule
`default_nettype wire

>>> rtl/srsc_axis.sv
// ----------------------------------------------------------------------------
// srsc_axis: clips one axis of a rectangle against the window.
// Stage one compares and finds overhangs, stage two multiplies, then the
// dividers run, and the last stage adjusts and saturates the coordinates.
// ----------------------------------------------------------------------------
`default_nettype none
module srsc_axis #(
  parameter int unsigned POS_BITS = 14,
  parameter int unsigned TEX_BITS = 18
) (
  input  wire logic                       clk_i,
  input  wire logic                       en_i,
  input  wire logic signed [POS_BITS-1:0] pos_i,
  input  wire logic        [POS_BITS-2:0] size_i,
  input  wire logic [srsc_pkg::WinPosBits-1:0]  wlo_i,
  input  wire logic [srsc_pkg::WinSizeBits-1:0] wsize_i,
  input  wire logic signed [TEX_BITS-1:0] t0_i,
  input  wire logic signed [TEX_BITS-1:0] t1_i,
  output logic                            vis_o,
  output logic signed [POS_BITS-1:0]      pos_o,
  output logic        [POS_BITS-2:0]      size_o,
  output logic signed [TEX_BITS-1:0]      t0_o,
  output logic signed [TEX_BITS-1:0]      t1_o
);

  localparam int unsigned CB = (POS_BITS + 2 > 16) ? POS_BITS + 2 : 16;
  localparam int unsigned SB = TEX_BITS + 1;
  localparam int unsigned PB = CB + SB;
  localparam int unsigned DB = PB + 34;
  localparam int unsigned Lat = PB;

  // Stage 1: window compare and overhangs.
  logic signed [CB-1:0] pos_w, end_w, wlo_w, whi_w;
  assign pos_w = CB'(pos_i);
  assign end_w = pos_w + CB'(size_i);
  assign wlo_w = CB'(wlo_i);
  assign whi_w = wlo_w + CB'(wsize_i);

  logic                 vis1_q, cl0_q, cl1_q;
  logic signed [CB-1:0] pos1_q, end1_q, ov0_q, ov1_q;
  logic signed [SB-1:0] span1_q;
  logic signed [TEX_BITS-1:0] t01_q, t11_q;
  logic [POS_BITS-2:0]  size1_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vis1_q  <= (size_i != '0) && (wsize_i != '0) && (end_w > wlo_w) && (pos_w < whi_w);
      cl0_q   <= pos_w < wlo_w;
      cl1_q   <= end_w > whi_w;
      pos1_q  <= (pos_w < wlo_w) ? wlo_w : pos_w;
      end1_q  <= (end_w > whi_w) ? whi_w : end_w;
      ov0_q   <= wlo_w - pos_w;
      ov1_q   <= end_w - whi_w;
      span1_q <= SB'(t1_i) - SB'(t0_i);
      t01_q   <= t0_i;
      t11_q   <= t1_i;
      size1_q <= size_i;
    end
  end

  // Stage 2: overhang times span.
  logic signed [PB-1:0] p0_q, p1_q;
  logic                 vis2_q, cl02_q, cl12_q;
  logic signed [CB-1:0] pos2_q, end2_q;
  logic signed [TEX_BITS-1:0] t02_q, t12_q;
  logic [POS_BITS-2:0]  size2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p0_q    <= PB'(ov0_q) * PB'(span1_q);
      p1_q    <= PB'(ov1_q) * PB'(span1_q);
      vis2_q  <= vis1_q;
      cl02_q  <= cl0_q;
      cl12_q  <= cl1_q;
      pos2_q  <= pos1_q;
      end2_q  <= end1_q;
      t02_q   <= t01_q;
      t12_q   <= t11_q;
      size2_q <= size1_q;
    end
  end

  // Division pipelines; a zero size only occurs on invisible beats.
  logic signed [PB-1:0] q0, q1;
  srsc_div #(.NUM_BITS(PB), .DEN_BITS(POS_BITS-1)) u_div0 (
    .clk_i, .en_i, .num_i(p0_q), .den_i(size2_q), .quo_o(q0));
  srsc_div #(.NUM_BITS(PB), .DEN_BITS(POS_BITS-1)) u_div1 (
    .clk_i, .en_i, .num_i(p1_q), .den_i(size2_q), .quo_o(q1));

  // Side data delayed alongside the dividers.
  logic                 visd_q [Lat+1];
  logic                 cl0d_q [Lat+1];
  logic                 cl1d_q [Lat+1];
  logic signed [CB-1:0] posd_q [Lat+1];
  logic signed [CB-1:0] endd_q [Lat+1];
  logic signed [TEX_BITS-1:0] t0d_q [Lat+1];
  logic signed [TEX_BITS-1:0] t1d_q [Lat+1];
  always_comb begin
    visd_q[0] = vis2_q; cl0d_q[0] = cl02_q; cl1d_q[0] = cl12_q;
    posd_q[0] = pos2_q; endd_q[0] = end2_q; t0d_q[0] = t02_q; t1d_q[0] = t12_q;
  end
  for (genvar i = 0; i < Lat; i++) begin : g_dly
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        visd_q[i+1] <= visd_q[i]; cl0d_q[i+1] <= cl0d_q[i]; cl1d_q[i+1] <= cl1d_q[i];
        posd_q[i+1] <= posd_q[i]; endd_q[i+1] <= endd_q[i];
        t0d_q[i+1] <= t0d_q[i]; t1d_q[i+1] <= t1d_q[i];
      end
    end
  end

  // Final stage: adjust and saturate.
  localparam logic signed [DB-1:0] Hi = DB'((1 << (TEX_BITS-1)) - 1);
  localparam logic signed [DB-1:0] Lo = -Hi - DB'(1);
  logic signed [DB-1:0] a0, a1;
  assign a0 = cl0d_q[Lat] ? DB'(t0d_q[Lat]) + DB'(q0) : DB'(t0d_q[Lat]);
  assign a1 = cl1d_q[Lat] ? DB'(t1d_q[Lat]) - DB'(q1) : DB'(t1d_q[Lat]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vis_o  <= visd_q[Lat];
      pos_o  <= POS_BITS'(posd_q[Lat]);
      size_o <= (POS_BITS-1)'(endd_q[Lat] - posd_q[Lat]);
      t0_o   <= (a0 > Hi) ? TEX_BITS'(Hi) : (a0 < Lo) ? TEX_BITS'(Lo) : TEX_BITS'(a0);
      t1_o   <= (a1 > Hi) ? TEX_BITS'(Hi) : (a1 < Lo) ? TEX_BITS'(Lo) : TEX_BITS'(a1);
    end
  end

endmodule
`default_nettype wire

>>> rtl/sprite_rect_scissor_clip_unit.sv
// ----------------------------------------------------------------------------
// sprite_rect_scissor_clip_unit: textured rectangle scissor clipper.
// Clips rectangles and their texture coordinates against a window.
// ----------------------------------------------------------------------------
// One rectangle is accepted every cycle (busy stays low). Its result is on
// the output ports with done_o once it has passed the two front stages of
// each axis pipeline, the bit-per-stage dividers that scale the texture
// overhang, the axis final stage and the output register. The receiver
// cannot stall, and results come out in order. Window registers must be
// written while no rectangle is in flight.
`default_nettype none
module sprite_rect_scissor_clip_unit #(
  parameter int unsigned POS_BITS = 14,
  parameter int unsigned TEX_FRAC_BITS = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start,
  output logic      busy,
  input  wire logic cfg_valid_i,
  output logic      cfg_ready_o,
  input  wire logic [srsc_pkg::CfgIdxBits-1:0]  cfg_index_i,
  input  wire logic [srsc_pkg::CfgDataBits-1:0] cfg_data_i,
  input  wire logic signed [POS_BITS-1:0] rect_x_i,
  input  wire logic signed [POS_BITS-1:0] rect_y_i,
  input  wire logic [POS_BITS-2:0] rect_w_i,
  input  wire logic [POS_BITS-2:0] rect_h_i,
  input  wire logic signed [TEX_FRAC_BITS+1:0] tex_u_start_i,
  input  wire logic signed [TEX_FRAC_BITS+1:0] tex_v_start_i,
  input  wire logic signed [TEX_FRAC_BITS+1:0] tex_u_end_i,
  input  wire logic signed [TEX_FRAC_BITS+1:0] tex_v_end_i,
  output logic      done_o,
  output logic      visible_o,
  output logic signed [POS_BITS-1:0] out_x_o,
  output logic signed [POS_BITS-1:0] out_y_o,
  output logic [POS_BITS-2:0] out_w_o,
  output logic [POS_BITS-2:0] out_h_o,
  output logic signed [TEX_FRAC_BITS+1:0] out_u_start_o,
  output logic signed [TEX_FRAC_BITS+1:0] out_v_start_o,
  output logic signed [TEX_FRAC_BITS+1:0] out_u_end_o,
  output logic signed [TEX_FRAC_BITS+1:0] out_v_end_o
);

  localparam int unsigned TB = TEX_FRAC_BITS + 2;
  localparam int unsigned CB = (POS_BITS + 2 > 16) ? POS_BITS + 2 : 16;
  localparam int unsigned Lat = CB + TB + 1 + 3;

  // Window registers.
  logic [srsc_pkg::WinPosBits-1:0]  wl_q, wt_q;
  logic [srsc_pkg::WinSizeBits-1:0] ww_q, wh_q;
  assign cfg_ready_o = 1'b1;
  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wl_q <= '0; wt_q <= '0; ww_q <= '0; wh_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (srsc_pkg::reg_idx_e'(cfg_index_i))
        srsc_pkg::REG_WINDOW_LEFT:   wl_q <= cfg_data_i[srsc_pkg::WinPosBits-1:0];
        srsc_pkg::REG_WINDOW_TOP:    wt_q <= cfg_data_i[srsc_pkg::WinPosBits-1:0];
        srsc_pkg::REG_WINDOW_WIDTH:  ww_q <= cfg_data_i;
        srsc_pkg::REG_WINDOW_HEIGHT: wh_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Two axis pipelines run in lockstep.
  logic xv, yv;
  logic signed [POS_BITS-1:0] xo, yo;
  logic [POS_BITS-2:0] wo, ho;
  logic signed [TB-1:0] u0, u1, v0, v1;

  srsc_axis #(.POS_BITS(POS_BITS), .TEX_BITS(TB)) u_x (
    .clk_i, .en_i(1'b1), .pos_i(rect_x_i), .size_i(rect_w_i), .wlo_i(wl_q),
    .wsize_i(ww_q), .t0_i(tex_u_start_i), .t1_i(tex_u_end_i),
    .vis_o(xv), .pos_o(xo), .size_o(wo), .t0_o(u0), .t1_o(u1));
  srsc_axis #(.POS_BITS(POS_BITS), .TEX_BITS(TB)) u_y (
    .clk_i, .en_i(1'b1), .pos_i(rect_y_i), .size_i(rect_h_i), .wlo_i(wt_q),
    .wsize_i(wh_q), .t0_i(tex_v_start_i), .t1_i(tex_v_end_i),
    .vis_o(yv), .pos_o(yo), .size_o(ho), .t0_o(v0), .t1_o(v1));

  // Valid bits travel beside the data.
  logic [Lat-1:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Lat-2:0], start};
    end
  end

  // Output register; invisible results are all zero.
  logic vis;
  assign vis = xv && yv;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= vld_q[Lat-1];
    end
  end
  always_ff @(posedge clk_i) begin
    visible_o     <= vis;
    out_x_o       <= vis ? xo : '0;
    out_y_o       <= vis ? yo : '0;
    out_w_o       <= vis ? wo : '0;
    out_h_o       <= vis ? ho : '0;
    out_u_start_o <= vis ? u0 : '0;
    out_u_end_o   <= vis ? u1 : '0;
    out_v_start_o <= vis ? v0 : '0;
    out_v_end_o   <= vis ? v1 : '0;
  end

`ifndef SYNTHESIS
  a_done_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(vld_q[Lat-1])) else $error("done without valid");
  a_invis_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !visible_o) |-> (out_w_o == '0 && out_h_o == '0))
    else $error("invisible result not cleared");
  a_vis_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && visible_o) |-> (out_w_o != '0 && out_h_o != '0))
    else $error("visible result with empty size");
  a_empty_win: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && visible_o) |-> (ww_q != '0 && wh_q != '0))
    else $error("visible with empty window");
`endif

endmodule
`default_nettype wire
